### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for the concurrent assertions of the rational unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RAU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types, constants and the microcode program of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   // Operand and datapath widths.
   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int VAL_WIDTH     = 2 * OPERAND_WIDTH + 1;
   localparam int CNT_WIDTH     = $clog2(VAL_WIDTH + 1);
   localparam int WHOLE_WIDTH   = 33;
   localparam int REM_WIDTH     = 32;
   localparam int DEN_WIDTH     = 32;
   localparam int STEP_WIDTH    = 5;

   typedef logic signed [OPERAND_WIDTH-1:0] operand_type;
   typedef logic signed [PROD_WIDTH-1:0]    prod_type;
   typedef logic signed [VAL_WIDTH-1:0]     val_type;
   typedef logic [STEP_WIDTH-1:0]           step_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   // Input item.
   typedef struct packed {
      opcode_type  opcode;
      operand_type left_num;
      operand_type left_den;
      operand_type right_num;
      operand_type right_den;
   } rau_req_type;

   // Result item.
   typedef struct packed {
      logic signed [WHOLE_WIDTH-1:0] whole_part;
      logic signed [REM_WIDTH-1:0]   rem_num;
      logic signed [DEN_WIDTH-1:0]   res_den;
      logic                          div_error;
   } rau_rsp_type;

   // Multiplier operand selection.
   typedef enum logic [1:0] {
      MUL_N1 = 2'd0,   // first numerator product
      MUL_N2 = 2'd1,   // right_num * left_den
      MUL_D  = 2'd2    // denominator product
   } mul_sel_type;

   // Datapath action of one step.
   typedef enum logic [3:0] {
      ACT_NONE     = 4'd0,
      ACT_ACCEPT   = 4'd1,
      ACT_LOAD_N   = 4'd2,
      ACT_ADD_N    = 4'd3,
      ACT_LOAD_D   = 4'd4,
      ACT_DIV_AB   = 4'd5,
      ACT_SWAP     = 4'd6,
      ACT_DIV_NG   = 4'd7,
      ACT_SET_N    = 4'd8,
      ACT_SET_D    = 4'd9,
      ACT_DIV_ND   = 4'd10,
      ACT_EMIT     = 4'd11,
      ACT_EMIT_ERR = 4'd12
   } act_type;

   // Jump condition of one step.
   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_REQ   = 3'd2,
      COND_OP_SHORT = 3'd3,
      COND_D_ZERO   = 3'd4,
      COND_B_ZERO   = 3'd5,
      COND_DIV_BUSY = 3'd6,
      COND_OUT_BUSY = 3'd7
   } cond_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      act_type     act;
      cond_type    cond;
      step_type    target;
   } ctrl_word_type;

   // Program step addresses.
   localparam step_type S_IDLE       = 5'd0;
   localparam step_type S_MUL_N1     = 5'd1;
   localparam step_type S_LOAD_N     = 5'd2;
   localparam step_type S_ADD_N      = 5'd3;
   localparam step_type S_MUL_D      = 5'd4;
   localparam step_type S_LOAD_D     = 5'd5;
   localparam step_type S_CHECK_D    = 5'd6;
   localparam step_type S_GCD_TEST   = 5'd7;
   localparam step_type S_GCD_DIV    = 5'd8;
   localparam step_type S_GCD_WAIT   = 5'd9;
   localparam step_type S_GCD_SWAP   = 5'd10;
   localparam step_type S_REDUCE     = 5'd11;
   localparam step_type S_RED_N_WAIT = 5'd12;
   localparam step_type S_SET_N      = 5'd13;
   localparam step_type S_RED_D_WAIT = 5'd14;
   localparam step_type S_SET_D      = 5'd15;
   localparam step_type S_FINAL_DIV  = 5'd16;
   localparam step_type S_FINAL_WAIT = 5'd17;
   localparam step_type S_EMIT       = 5'd18;
   localparam step_type S_DONE       = 5'd19;
   localparam step_type S_ERROR      = 5'd20;
   localparam step_type S_ERR_DONE   = 5'd21;

   // Microcode read-only table: one control word per step.
   function automatic ctrl_word_type microcode(input step_type step);
      ctrl_word_type word;
      word = '{mul_sel: MUL_N1, act: ACT_NONE, cond: COND_NEXT, target: S_IDLE};
      case (step)
         S_IDLE:       word = '{MUL_N1, ACT_ACCEPT,   COND_NO_REQ,   S_IDLE};
         S_MUL_N1:     word = '{MUL_N1, ACT_NONE,     COND_NEXT,     S_IDLE};
         S_LOAD_N:     word = '{MUL_N2, ACT_LOAD_N,   COND_OP_SHORT, S_MUL_D};
         S_ADD_N:      word = '{MUL_D,  ACT_ADD_N,    COND_ALWAYS,   S_LOAD_D};
         S_MUL_D:      word = '{MUL_D,  ACT_NONE,     COND_NEXT,     S_IDLE};
         S_LOAD_D:     word = '{MUL_N1, ACT_LOAD_D,   COND_NEXT,     S_IDLE};
         S_CHECK_D:    word = '{MUL_N1, ACT_NONE,     COND_D_ZERO,   S_ERROR};
         S_GCD_TEST:   word = '{MUL_N1, ACT_NONE,     COND_B_ZERO,   S_REDUCE};
         S_GCD_DIV:    word = '{MUL_N1, ACT_DIV_AB,   COND_NEXT,     S_IDLE};
         S_GCD_WAIT:   word = '{MUL_N1, ACT_NONE,     COND_DIV_BUSY, S_GCD_WAIT};
         S_GCD_SWAP:   word = '{MUL_N1, ACT_SWAP,     COND_ALWAYS,   S_GCD_TEST};
         S_REDUCE:     word = '{MUL_N1, ACT_DIV_NG,   COND_NEXT,     S_IDLE};
         S_RED_N_WAIT: word = '{MUL_N1, ACT_NONE,     COND_DIV_BUSY, S_RED_N_WAIT};
         S_SET_N:      word = '{MUL_N1, ACT_SET_N,    COND_NEXT,     S_IDLE};
         S_RED_D_WAIT: word = '{MUL_N1, ACT_NONE,     COND_DIV_BUSY, S_RED_D_WAIT};
         S_SET_D:      word = '{MUL_N1, ACT_SET_D,    COND_NEXT,     S_IDLE};
         S_FINAL_DIV:  word = '{MUL_N1, ACT_DIV_ND,   COND_NEXT,     S_IDLE};
         S_FINAL_WAIT: word = '{MUL_N1, ACT_NONE,     COND_DIV_BUSY, S_FINAL_WAIT};
         S_EMIT:       word = '{MUL_N1, ACT_EMIT,     COND_OUT_BUSY, S_EMIT};
         S_DONE:       word = '{MUL_N1, ACT_NONE,     COND_ALWAYS,   S_IDLE};
         S_ERROR:      word = '{MUL_N1, ACT_EMIT_ERR, COND_OUT_BUSY, S_ERROR};
         S_ERR_DONE:   word = '{MUL_N1, ACT_NONE,     COND_ALWAYS,   S_IDLE};
         default:      word = '{MUL_N1, ACT_NONE,     COND_ALWAYS,   S_IDLE};
      endcase
      return word;
   endfunction

endpackage

### src/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rau_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rau_pkg::val_type dividend,
   input  rau_pkg::val_type divisor,
   output logic             busy,
   output rau_pkg::val_type quotient,
   output rau_pkg::val_type remainder
);

   localparam int VW = rau_pkg::VAL_WIDTH;
   localparam int CW = rau_pkg::CNT_WIDTH;

   logic [VW-1:0] q_ff, q_in;
   logic [VW-1:0] r_ff, r_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_q_ff, neg_q_in;
   logic          neg_r_ff, neg_r_in;

   logic [VW-1:0] dvd_mag;
   logic [VW-1:0] dvs_mag;
   logic [VW:0]   shifted;
   logic [VW:0]   diff;

   // Operand magnitudes; the most negative value maps onto its unsigned bits.
   assign dvd_mag = dividend[VW-1] ? (~dividend + 1'b1) : dividend;
   assign dvs_mag = divisor[VW-1]  ? (~divisor + 1'b1)  : divisor;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign shifted = {r_ff, q_ff[VW-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   assign busy = (cnt_ff != '0);

   // Sign correction: quotient by the sign rule, remainder follows the dividend.
   assign quotient  = neg_q_ff ? rau_pkg::val_type'(~q_ff + 1'b1) : rau_pkg::val_type'(q_ff);
   assign remainder = neg_r_ff ? rau_pkg::val_type'(~r_ff + 1'b1) : rau_pkg::val_type'(r_ff);

   // Next-state logic.
   always_comb begin
      q_in     = q_ff;
      r_in     = r_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (start) begin
         q_in     = dvd_mag;
         r_in     = '0;
         dvs_in   = dvs_mag;
         cnt_in   = CW'(VW);
         neg_q_in = dividend[VW-1] ^ divisor[VW-1];
         neg_r_in = dividend[VW-1];
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         if (!diff[VW]) begin
            r_in = diff[VW-1:0];
            q_in = {q_ff[VW-2:0], 1'b1};
         end else begin
            r_in = shifted[VW-1:0];
            q_in = {q_ff[VW-2:0], 1'b0};
         end
      end
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      r_ff     <= r_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

endmodule

### src/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Fraction add, subtract, multiply and divide with signed gcd reduction.
// ----------------------------------------------------------------------------
// The unit takes one item at a time: an opcode and two signed 16-bit
// fractions. It forms the raw numerator and denominator with one 16x16
// multiplier, reduces both by the Euclidean gcd (truncating remainder, so
// the gcd may be negative) and returns the truncated whole part, the
// remainder numerator and the reduced denominator. A zero denominator
// returns div_error with all other fields zero. Otherwise the time of an
// item is set by the single shared bit-serial divider, which runs once
// per Euclid step (at most about 48 steps for 33-bit values) and three
// more times for the reduction and the final split. A finished result
// waits in an output register while the next item is already accepted
// and processed.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rau_pkg::rau_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rau_pkg::rau_rsp_type rsp_data
);

   localparam int VW = rau_pkg::VAL_WIDTH;
   localparam int PW = rau_pkg::PROD_WIDTH;

   // Sequencer and datapath registers.
   rau_pkg::step_type    pc_ff, pc_in;
   rau_pkg::rau_req_type req_ff, req_in;
   rau_pkg::prod_type    prod_ff, prod_in;
   rau_pkg::val_type     a_ff, a_in;
   rau_pkg::val_type     b_ff, b_in;
   rau_pkg::val_type     n_ff, n_in;
   rau_pkg::val_type     d_ff, d_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rau_pkg::rau_rsp_type rsp_ff, rsp_in;

   rau_pkg::ctrl_word_type ctrl;
   rau_pkg::operand_type   mul_x;
   rau_pkg::operand_type   mul_y;
   rau_pkg::val_type       prod_ext;
   rau_pkg::val_type       div_dividend;
   rau_pkg::val_type       div_divisor;
   rau_pkg::val_type       div_quo;
   rau_pkg::val_type       div_rem;
   logic                   div_start;
   logic                   div_busy;
   logic                   out_busy;
   logic                   taken;

   // Control word of the current step.
   assign ctrl = rau_pkg::microcode(pc_ff);

   assign out_busy  = rsp_valid_ff & ~rsp_ready;
   assign req_ready = (pc_ff == rau_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Multiplier operand selection; the opcode picks the cross products.
   always_comb begin
      case (ctrl.mul_sel)
         rau_pkg::MUL_N1: begin
            mul_x = req_ff.left_num;
            mul_y = (req_ff.opcode == rau_pkg::OP_MUL) ? req_ff.right_num : req_ff.right_den;
         end
         rau_pkg::MUL_N2: begin
            mul_x = req_ff.right_num;
            mul_y = req_ff.left_den;
         end
         rau_pkg::MUL_D: begin
            mul_x = req_ff.left_den;
            mul_y = (req_ff.opcode == rau_pkg::OP_DIV) ? req_ff.right_num : req_ff.right_den;
         end
         default: begin
            mul_x = req_ff.left_den;
            mul_y = req_ff.right_den;
         end
      endcase
   end

   assign prod_in  = PW'(mul_x) * PW'(mul_y);
   assign prod_ext = VW'(prod_ff);

   // Divider operand selection.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = n_ff;
      div_divisor  = d_ff;
      case (ctrl.act)
         rau_pkg::ACT_DIV_AB: begin
            div_start    = 1'b1;
            div_dividend = a_ff;
            div_divisor  = b_ff;
         end
         rau_pkg::ACT_DIV_NG: begin
            div_start    = 1'b1;
            div_dividend = n_ff;
            div_divisor  = a_ff;
         end
         rau_pkg::ACT_SET_N: begin
            div_start    = 1'b1;
            div_dividend = d_ff;
            div_divisor  = a_ff;
         end
         rau_pkg::ACT_DIV_ND: begin
            div_start    = 1'b1;
            div_dividend = n_ff;
            div_divisor  = d_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   rau_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Datapath actions.
   always_comb begin
      req_in       = req_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (ctrl.act)
         rau_pkg::ACT_ACCEPT: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         rau_pkg::ACT_LOAD_N: begin
            a_in = prod_ext;
         end
         rau_pkg::ACT_ADD_N: begin
            a_in = (req_ff.opcode == rau_pkg::OP_SUB) ? (a_ff - prod_ext) : (a_ff + prod_ext);
         end
         rau_pkg::ACT_LOAD_D: begin
            n_in = a_ff;
            b_in = prod_ext;
            d_in = prod_ext;
         end
         rau_pkg::ACT_SWAP: begin
            a_in = b_ff;
            b_in = div_rem;
         end
         rau_pkg::ACT_SET_N: begin
            n_in = div_quo;
         end
         rau_pkg::ACT_SET_D: begin
            d_in = div_quo;
         end
         rau_pkg::ACT_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in       = 1'b1;
               rsp_in.whole_part  = rau_pkg::WHOLE_WIDTH'(div_quo);
               rsp_in.rem_num     = rau_pkg::REM_WIDTH'(div_rem);
               rsp_in.res_den     = rau_pkg::DEN_WIDTH'(d_ff);
               rsp_in.div_error   = 1'b0;
            end
         end
         rau_pkg::ACT_EMIT_ERR: begin
            if (!out_busy) begin
               rsp_valid_in       = 1'b1;
               rsp_in.whole_part  = '0;
               rsp_in.rem_num     = '0;
               rsp_in.res_den     = '0;
               rsp_in.div_error   = 1'b1;
            end
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   // Step counter with conditional jumps.
   always_comb begin
      case (ctrl.cond)
         rau_pkg::COND_NEXT:     taken = 1'b0;
         rau_pkg::COND_ALWAYS:   taken = 1'b1;
         rau_pkg::COND_NO_REQ:   taken = ~req_valid;
         rau_pkg::COND_OP_SHORT: taken = req_ff.opcode inside {rau_pkg::OP_MUL, rau_pkg::OP_DIV};
         rau_pkg::COND_D_ZERO:   taken = (d_ff == '0);
         rau_pkg::COND_B_ZERO:   taken = (b_ff == '0);
         rau_pkg::COND_DIV_BUSY: taken = div_busy;
         rau_pkg::COND_OUT_BUSY: taken = out_busy;
         default:                taken = 1'b0;
      endcase
      pc_in = taken ? ctrl.target : (pc_ff + 1'b1);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= rau_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prod_ff <= prod_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      rsp_ff  <= rsp_in;
   end

endmodule

### src/rau_core_checker.sv
// ----------------------------------------------------------------------------
// rau_core_checker
// Port-level assertions for the rational arithmetic unit, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_core_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rau_pkg::rau_rsp_type rsp_data
);

   // A waiting result stays offered.
   `RAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result item dropped while stalled")

   // A waiting result keeps its payload.
   `RAU_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "result item changed while stalled")

   // An error item carries only zero fields.
   `RAU_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_data.div_error, rsp_data.whole_part == 0 && rsp_data.rem_num == 0 && rsp_data.res_den == 0, "error item with nonzero fields")

   // The unit works on one item at a time.
   `RAU_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item taken while busy")

endmodule

bind rational_arithmetic_unit_core rau_core_checker u_rau_core_checker (.*);
